// ===== src/subscriber_ready_qualifier_core_assert.svh =====
// Assertion macros for the subscriber ready qualifier checker.
// Expect clk_i and rst_ni in the scope of use.
`ifndef SUBSCRIBER_READY_QUALIFIER_CORE_ASSERT_SVH
`define SUBSCRIBER_READY_QUALIFIER_CORE_ASSERT_SVH

// General clocked assertion, disabled during reset.
`define SRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal must hold while the result channel is stalled.
`define SRQ_ASSERT_STALL_HOLD(lbl, sig, msg) \
  `SRQ_ASSERT(lbl, (out_valid_o && !out_ready_i) |=> $stable(sig), msg)

`endif

// ===== src/srq_pkg.sv =====
// Shared types and constants of the subscriber ready qualifier.
// No dependencies.
package srq_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int TimeW    = 63;
  localparam int NsW      = 52;  // 32-bit ms times 10^6 fits in 52 bits

  localparam logic [19:0]      NsPerMs   = 20'd1000000;
  localparam logic [TimeW-1:0] MaxTime   = {TimeW{1'b1}};
  localparam logic [NsW-1:0]   PollRstNs = 52'd100000000;

  localparam logic StatReady = 1'b0;
  localparam logic StatWait  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    RegNeedCount  = 3'd0,
    RegPollMs     = 3'd1,
    RegSettleMs   = 3'd2,
    RegLatchEn    = 3'd3,
    RegCheckEn    = 3'd4
  } srq_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ns;
    logic [31:0]      sub_count;
  } srq_in_t;

  typedef struct packed {
    logic             status;
    logic [TimeW-1:0] target_ns;
  } srq_out_t;

  typedef struct packed {
    logic [31:0]    need_count;
    logic [NsW-1:0] poll_ns;
    logic [NsW-1:0] settle_ns;
    logic           settle_en;
    logic           latch_en;
    logic           check_en;
  } srq_cfg_t;

  // Add two times below 2^63, clamp at the largest time
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [NsW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {{(TimeW+1-NsW){1'b0}}, b};
    return sum[TimeW] ? MaxTime : sum[TimeW-1:0];
  endfunction

endpackage

// ===== src/srq_cfg.sv =====
// Configuration registers; stores poll and settle periods already scaled to ns.
// Depends on srq_pkg.
module srq_cfg import srq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output srq_cfg_t            cfg_o
);

  srq_cfg_t       cfg_q, cfg_d;
  logic [31:0]    poll_ms_eff;
  logic [NsW-1:0] poll_prod;
  logic [NsW-1:0] settle_prod;

  // Scale on the way in; zero poll counts as one millisecond
  assign poll_ms_eff = (cfg_wdata_i == 32'd0) ? 32'd1 : cfg_wdata_i;
  assign poll_prod   = {20'd0, poll_ms_eff} * {32'd0, NsPerMs};
  assign settle_prod = {20'd0, cfg_wdata_i} * {32'd0, NsPerMs};

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (srq_reg_e'(cfg_idx_i))
        RegNeedCount: cfg_d.need_count = cfg_wdata_i;
        RegPollMs:   cfg_d.poll_ns   = poll_prod;
        RegSettleMs: begin
          cfg_d.settle_ns = settle_prod;
          cfg_d.settle_en = (cfg_wdata_i != 32'd0);
        end
        RegLatchEn:  cfg_d.latch_en  = cfg_wdata_i[0];
        RegCheckEn:  cfg_d.check_en  = cfg_wdata_i[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.need_count <= 32'd1;
      cfg_q.poll_ns    <= PollRstNs;
      cfg_q.settle_ns  <= '0;
      cfg_q.settle_en  <= 1'b0;
      cfg_q.latch_en   <= 1'b0;
      cfg_q.check_en   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/srq_eval.sv =====
// Per-item decision logic and the match/latch state it updates.
// Depends on srq_pkg.
module srq_eval import srq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  srq_in_t  item_i,
  input  srq_cfg_t cfg_i,
  output srq_out_t result_o
);

  logic             sticky_q, sticky_d;
  logic             seen_q, seen_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             was_ready_q, was_ready_d;

  logic             matched;
  logic [TimeW-1:0] start_eff;
  logic [TimeW-1:0] poll_until;
  logic [TimeW-1:0] settle_until;
  logic             ready;

  assign matched      = !cfg_i.check_en || (item_i.sub_count >= cfg_i.need_count);
  assign start_eff    = seen_q ? start_q : item_i.now_ns;
  assign poll_until   = sat_add(item_i.now_ns, cfg_i.poll_ns);
  assign settle_until = sat_add(start_eff, cfg_i.settle_ns);

  always_comb begin
    sticky_d           = sticky_q;
    seen_d             = seen_q;
    start_d            = start_q;
    ready              = 1'b1;
    result_o.target_ns = item_i.now_ns;
    if (cfg_i.latch_en && sticky_q) begin
      ready = 1'b1;
    end else if (!matched) begin
      seen_d             = 1'b0;
      ready              = 1'b0;
      result_o.target_ns = poll_until;
    end else if (cfg_i.settle_en) begin
      seen_d  = 1'b1;
      start_d = start_eff;
      ready   = (item_i.now_ns >= settle_until);
      if (!ready) begin
        result_o.target_ns = settle_until;
      end
    end else begin
      seen_d  = 1'b1;
      start_d = item_i.now_ns;
    end
    // Latch on the first transition to ready
    if (ready && !was_ready_q && cfg_i.latch_en) begin
      sticky_d = 1'b1;
    end
    was_ready_d     = ready;
    result_o.status = ready ? StatReady : StatWait;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_q    <= 1'b0;
      seen_q      <= 1'b0;
      start_q     <= '0;
      was_ready_q <= 1'b0;
    end else if (adv_i) begin
      sticky_q    <= sticky_d;
      seen_q      <= seen_d;
      start_q     <= start_d;
      was_ready_q <= was_ready_d;
    end
  end

endmodule

// ===== src/subscriber_ready_qualifier_core.sv =====
// Subscriber ready qualifier: one result per tick, ready or wait with a target time.
// Path: input register, then decision and state update, then result register.
// Throughput: one item per cycle unless out_ready_i stalls the result.
// Reset clears the match and latch state and loads the register defaults
// (min count 1, poll 100 ms, settle off, latch off, check on); both stages empty.
// Depends on srq_pkg, srq_cfg and srq_eval.
module subscriber_ready_qualifier_core import srq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srq_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srq_out_t            out_data_o
);

  srq_cfg_t cfg;
  srq_in_t  s1_item_q;
  logic     s1_valid_q, s1_valid_d;
  srq_out_t result;
  srq_out_t out_q;
  logic     out_valid_q;
  logic     out_free;
  logic     s1_adv;
  logic     in_acc;

  srq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  srq_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  // Hold the staged item while the result register is full and stalled
  assign s1_valid_d = (s1_valid_q && !out_free) || in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/srq_checker.sv =====
// Port-level checks of the subscriber ready qualifier, bound to the top level.
// Depends on srq_pkg and subscriber_ready_qualifier_core_assert.svh.
`include "subscriber_ready_qualifier_core_assert.svh"

module srq_checker import srq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input srq_out_t out_data_o
);

  `SRQ_ASSERT_STALL_HOLD(a_out_valid_hold, out_valid_o, "result valid dropped while stalled")
  `SRQ_ASSERT_STALL_HOLD(a_out_data_hold, out_data_o, "result changed while stalled")
  `SRQ_ASSERT(a_stall_needs_full, !in_ready_o |-> out_valid_o, "input stalled with result empty")
  `SRQ_ASSERT(a_wait_target_set, (out_valid_o && out_data_o.status == StatWait) |-> out_data_o.target_ns != '0, "wait result malformed")

endmodule

bind subscriber_ready_qualifier_core srq_checker u_srq_checker (.*);
